FILE: hdl/cbfm_pkg.sv
`default_nettype none
package cbfm_pkg;

  localparam int MAX_TARGETS = 8;
  localparam int FLAG_BITS   = 16;

  // cells in the chain: never more than the eight targets the registers hold
  localparam int TGT_LIMIT = (MAX_TARGETS < 8) ? MAX_TARGETS : 8;

  localparam logic [15:0] FLAG_MASK = 16'((33'(1) << FLAG_BITS) - 33'(1));

  // configuration register indexes
  localparam logic [1:0] REG_TARGET_COUNT = 2'd0;
  localparam logic [1:0] REG_MASKS_LOW    = 2'd1;
  localparam logic [1:0] REG_MASKS_HIGH   = 2'd2;

  // match kinds
  localparam logic [1:0] KIND_COVER    = 2'd0;
  localparam logic [1:0] KIND_OVERLAP  = 2'd1;
  localparam logic [1:0] KIND_FALLBACK = 2'd2;

  typedef struct packed {
    logic [15:0] request_mask;
    logic        restart;
  } in_t;

  typedef struct packed {
    logic [2:0] chosen_target;
    logic [1:0] match_kind;
    logic       was_already_used;
  } out_t;

  // running best candidates handed from cell to cell
  typedef struct packed {
    logic [15:0] want;
    logic [3:0]  count;
    logic        cov_found;
    logic        cov_used;
    logic [2:0]  cov_idx;
    logic [4:0]  cov_extra;
    logic        ovl_found;
    logic        ovl_used;
    logic [2:0]  ovl_idx;
    logic [4:0]  ovl_count;
  } tok_t;

  function automatic logic [4:0] bit_total(input logic [15:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      n = n + 5'(v[i]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/capability_best_fit_matcher.sv
// a transaction passes one input stage, one register in each of the 8 target cells
// and one output register before its result is offered
// only a single token walks the cell chain, so a new transaction is taken only after the last one has left it
// a stalled result holds the chain; the next request is taken once the result is registered
// reset (rst, synchronous) clears used marks, the chain and the output valid,
// and sets target_count to 1 and both mask registers to zero
`default_nettype none
module capability_best_fit_matcher (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire cbfm_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output cbfm_pkg::out_t       out_data,
  input  wire logic            cfg_write,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [63:0]     cfg_data
);
  import cbfm_pkg::*;

  localparam int N = TGT_LIMIT;

  logic [3:0]  target_count;
  logic [63:0] target_masks_low;
  logic [63:0] target_masks_high;

  tok_t        tok   [0:N];
  logic        vld   [0:N];
  logic [N:0]  vld_vec;
  logic [7:0]  used8;
  logic [7:0]  set_vec;
  logic        accept;
  logic        advance;
  logic        commit;
  logic        busy;
  logic        clear;
  logic [3:0]  count_sat;
  out_t        res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_count      <= 4'd1;
      target_masks_low  <= '0;
      target_masks_high <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TARGET_COUNT: target_count      <= cfg_data[3:0];
        REG_MASKS_LOW:    target_masks_low  <= cfg_data;
        REG_MASKS_HIGH:   target_masks_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k <= N; k++) begin
      vld_vec[k] = vld[k];
    end
    busy      = |vld_vec;
    in_stall  = busy;
    accept    = in_valid && !busy;
    clear     = accept && in_data.restart;
    advance   = !(vld[N] && out_valid && out_stall);
    commit    = vld[N] && advance;
    count_sat = (target_count > 4'(N)) ? 4'(N) : target_count;
  end

  // input stage: fresh token with empty candidates
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (accept) begin
      vld[0] <= 1'b1;
    end else if (advance) begin
      vld[0] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok[0].want      <= in_data.request_mask & FLAG_MASK;
      tok[0].count     <= count_sat;
      tok[0].cov_found <= 1'b0;
      tok[0].cov_used  <= 1'b1;
      tok[0].cov_idx   <= '0;
      tok[0].cov_extra <= '0;
      tok[0].ovl_found <= 1'b0;
      tok[0].ovl_used  <= 1'b1;
      tok[0].ovl_idx   <= '0;
      tok[0].ovl_count <= '0;
    end
  end

  always_comb begin
    res_next = '0;
    if (tok[N].cov_found) begin
      res_next.chosen_target = tok[N].cov_idx;
      res_next.match_kind    = KIND_COVER;
    end else if (tok[N].ovl_found) begin
      res_next.chosen_target = tok[N].ovl_idx;
      res_next.match_kind    = KIND_OVERLAP;
    end else begin
      res_next.chosen_target = 3'd0;
      res_next.match_kind    = KIND_FALLBACK;
    end
    res_next.was_already_used = used8[res_next.chosen_target];
    set_vec = commit ? (8'd1 << res_next.chosen_target) : 8'd0;
  end

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_cell
      logic [15:0] cell_mask;
      logic        cell_used;
      assign cell_mask = (k < 4) ? target_masks_low[16*(k%4) +: 16]
                                 : target_masks_high[16*(k%4) +: 16];
      cbfm_cell u_cell (
        .clk           (clk),
        .rst           (rst),
        .index         (3'(k)),
        .mask          (cell_mask),
        .advance       (advance),
        .clear         (clear),
        .set           (set_vec[k]),
        .tok_in_valid  (vld[k]),
        .tok_in        (tok[k]),
        .tok_out_valid (vld[k+1]),
        .tok_out       (tok[k+1]),
        .used          (cell_used)
      );
      assign used8[k] = cell_used;
    end
    for (k = N; k < 8; k++) begin : g_pad
      assign used8[k] = 1'b0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data <= res_next;
    end
  end

`ifndef SYNTH
  // one request in flight at a time
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(vld_vec))
    else $error("more than one token in the cell chain");

  a_mark_set: assert property (@(posedge clk) disable iff (rst)
    commit |=> used8[$past(res_next.chosen_target)])
    else $error("chosen target not marked used");

  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    clear |=> (used8 == 8'd0))
    else $error("restart did not clear used marks");

  a_fallback_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.match_kind == KIND_FALLBACK) |-> (out_data.chosen_target == 3'd0))
    else $error("fallback result not on target zero");
`endif

endmodule
`default_nettype wire

FILE: hdl/cbfm_cell.sv
`default_nettype none
module cbfm_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [2:0]    index,
  input  wire logic [15:0]   mask,
  input  wire logic          advance,
  input  wire logic          clear,
  input  wire logic          set,
  input  wire logic          tok_in_valid,
  input  wire cbfm_pkg::tok_t tok_in,
  output logic               tok_out_valid,
  output cbfm_pkg::tok_t     tok_out,
  output logic               used
);
  import cbfm_pkg::*;

  logic [15:0] m;
  logic        active;
  logic        covers;
  logic [4:0]  extra;
  logic [4:0]  ov;
  tok_t        tok_next;

  always_comb begin
    m        = mask & FLAG_MASK;
    active   = {1'b0, index} < tok_in.count;
    covers   = (m & tok_in.want) == tok_in.want;
    extra    = bit_total(m & ~tok_in.want);
    ov       = bit_total(m & tok_in.want);
    tok_next = tok_in;
    if (active && covers &&
        (!tok_in.cov_found || (!used && tok_in.cov_used) ||
         (used == tok_in.cov_used && extra < tok_in.cov_extra))) begin
      tok_next.cov_found = 1'b1;
      tok_next.cov_used  = used;
      tok_next.cov_idx   = index;
      tok_next.cov_extra = extra;
    end
    if (active && ov != 5'd0 &&
        (!tok_in.ovl_found || (!used && tok_in.ovl_used) ||
         (used == tok_in.ovl_used && ov > tok_in.ovl_count))) begin
      tok_next.ovl_found = 1'b1;
      tok_next.ovl_used  = used;
      tok_next.ovl_idx   = index;
      tok_next.ovl_count = ov;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
      used          <= 1'b0;
    end else begin
      if (advance) begin
        tok_out_valid <= tok_in_valid;
      end
      if (clear) begin
        used <= 1'b0;
      end else if (set) begin
        used <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok_in_valid) begin
      tok_out <= tok_next;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb_capability_best_fit_matcher.sv
`default_nettype none
module tb_capability_best_fit_matcher;
  import cbfm_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // local copy of the register file and the used marks
  logic [3:0]  cfg_count = 4'd1;
  logic [63:0] cfg_low = '0;
  logic [63:0] cfg_high = '0;
  logic [7:0]  target_used = '0;

  out_t pending_matches[$];
  int   errors = 0;
  int   requests_sent = 0;
  int   restarts_sent = 0;
  int   tables_loaded = 0;
  int   results_checked = 0;
  int   cycles = 0;
  int   stall_left = 0;
  bit   src_gaps = 1'b1;
  bit   sink_gaps = 1'b1;

  capability_best_fit_matcher dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_matches.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] target_mask(input int t);
    return ((t < 4) ? cfg_low[16*t +: 16] : cfg_high[16*(t-4) +: 16]) & FLAG_MASK;
  endfunction

  // best-fit choice for one request; updates the used marks
  function automatic out_t predict_match(input in_t item);
    logic [15:0] want;
    logic [15:0] tmask;
    int   n, extra, ov, cov_idx, cov_extra, ovl_idx, ovl_count;
    bit   cov_found, cov_used, ovl_found, ovl_used, u;
    out_t res;
    want = item.request_mask & FLAG_MASK;
    n = (cfg_count > TGT_LIMIT) ? TGT_LIMIT : cfg_count;
    cov_found = 1'b0;
    cov_used = 1'b1;
    cov_idx = 0;
    cov_extra = 0;
    ovl_found = 1'b0;
    ovl_used = 1'b1;
    ovl_idx = 0;
    ovl_count = 0;
    if (item.restart) target_used = '0;
    for (int t = 0; t < n; t++) begin
      tmask = target_mask(t);
      u = target_used[t];
      if ((tmask & want) == want) begin
        extra = $countones(tmask & ~want);
        if (!cov_found || (!u && cov_used) || (u == cov_used && extra < cov_extra)) begin
          cov_found = 1'b1;
          cov_idx = t;
          cov_used = u;
          cov_extra = extra;
        end
      end
      ov = $countones(tmask & want);
      if (ov > 0 && (!ovl_found || (!u && ovl_used) || (u == ovl_used && ov > ovl_count))) begin
        ovl_found = 1'b1;
        ovl_idx = t;
        ovl_used = u;
        ovl_count = ov;
      end
    end
    if (cov_found) begin
      res.chosen_target = 3'(cov_idx);
      res.match_kind = KIND_COVER;
    end else if (ovl_found) begin
      res.chosen_target = 3'(ovl_idx);
      res.match_kind = KIND_OVERLAP;
    end else begin
      res.chosen_target = 3'd0;
      res.match_kind = KIND_FALLBACK;
    end
    res.was_already_used = target_used[res.chosen_target];
    target_used[res.chosen_target] = 1'b1;
    return res;
  endfunction

  // result side: check each accepted transaction, stall in random bursts
  always @(posedge clk) begin
    out_t want_res;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (pending_matches.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: target %0d kind %0d used %0d",
                   out_data.chosen_target, out_data.match_kind, out_data.was_already_used);
      end else begin
        want_res = pending_matches.pop_front();
        if (out_data.chosen_target !== want_res.chosen_target ||
            out_data.match_kind !== want_res.match_kind ||
            out_data.was_already_used !== want_res.was_already_used) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected target %0d kind %0d used %0d, got %0d %0d %0d",
                     want_res.chosen_target, want_res.match_kind,
                     want_res.was_already_used, out_data.chosen_target,
                     out_data.match_kind, out_data.was_already_used);
        end
      end
    end
    if (stall_left > 0)
      stall_left--;
    else if (sink_gaps && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 10);
    out_stall <= (stall_left > 0);
  end

  // valid stays high after a transaction unless a gap or a drain lowers it
  task automatic send_request(input logic [15:0] mask, input logic restart);
    in_t item;
    item.request_mask = mask;
    item.restart = restart;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    pending_matches = {pending_matches, predict_match(item)};
    requests_sent++;
    if (restart) restarts_sent++;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TARGET_COUNT: cfg_count = val[3:0];
      REG_MASKS_LOW:    cfg_low = val;
      REG_MASKS_HIGH:   cfg_high = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [3:0] count, input logic [63:0] low,
                              input logic [63:0] high);
    wait_all_results();
    write_reg(REG_TARGET_COUNT, 64'(count));
    write_reg(REG_MASKS_LOW, low);
    write_reg(REG_MASKS_HIGH, high);
    tables_loaded++;
  endtask

  function automatic logic [15:0] rand_mask();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom) & 16'($urandom) & 16'($urandom);
      3: return 16'($urandom) | 16'($urandom);
      default: return 16'($urandom);
    endcase
  endfunction

  // half the requests shaped after a configured target so covers and overlaps both occur
  function automatic logic [15:0] rand_request();
    logic [15:0] tm;
    tm = target_mask($urandom_range(0, 7));
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return tm & 16'($urandom);
      4: return tm | (16'h1 << $urandom_range(0, 15));
      5: return tm;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_reset_values();
    // one target with an empty mask: empty request covers it, full request falls back
    send_request(16'h0000, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0001, 1'b1);
  endtask

  task automatic test_directed_table();
    apply_config(4'd8, {16'h00FF, 16'h0F0F, 16'h00F0, 16'h000F},
                 {16'hFFFF, 16'h8000, 16'h0000, 16'h0003});
    send_request(16'h0000, 1'b1);
    send_request(16'h0001, 1'b0);
    send_request(16'h0001, 1'b0);
    send_request(16'h0003, 1'b0);
    send_request(16'h8000, 1'b0);
    send_request(16'h8000, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0110, 1'b0);
    // without the all-ones target: partial overlaps and a fallback
    apply_config(4'd7, {16'h00FF, 16'h0F0F, 16'h00F0, 16'h000F},
                 {16'hFFFF, 16'h8000, 16'h0000, 16'h0003});
    send_request(16'hF0F0, 1'b1);
    send_request(16'hF0F0, 1'b0);
    send_request(16'h7000, 1'b0);
  endtask

  task automatic test_count_edges();
    apply_config(4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(16'h0000, 1'b0);
    send_request(16'hFFFF, 1'b0);
    // counts above eight saturate
    apply_config(4'd9, 64'h1111_2222_4444_8888, 64'hF000_0F00_00F0_000F);
    send_request(16'h000F, 1'b0);
    send_request(16'h8000, 1'b1);
    apply_config(4'd15, 64'h1111_2222_4444_8888, 64'hF000_0F00_00F0_000F);
    send_request(16'hF000, 1'b0);
    // write to the unused index must change nothing
    wait_all_results();
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(16'h00F0, 1'b0);
    send_request(16'h0F00, 1'b0);
  endtask

  task automatic test_random_tables();
    logic [3:0]  count;
    logic [63:0] low, high;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: count = 4'd8;
        1: count = 4'd1;
        2: count = 4'd0;
        3: count = 4'd15;
        default: count = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(1, 8));
      endcase
      for (int t = 0; t < 4; t++) begin
        low[16*t +: 16] = rand_mask();
        high[16*t +: 16] = rand_mask();
      end
      if (phase == 4) begin
        low = '1;
        high = '1;
      end else if (phase == 5) begin
        low = '0;
        high = '0;
      end
      apply_config(count, low, high);
      src_gaps = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 80; i++)
        send_request(rand_request(), ($urandom_range(0, 9) == 0));
    end
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_back_to_back();
    apply_config(4'd8, {rand_mask(), rand_mask(), rand_mask(), rand_mask()},
                 {rand_mask(), rand_mask(), rand_mask(), rand_mask()});
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    for (int i = 0; i < 60; i++)
      send_request(rand_request(), ($urandom_range(0, 9) == 0));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_table();
    test_count_edges();
    test_random_tables();
    test_back_to_back();
    wait_all_results();
    errors += pending_matches.size();
    $display("%0d requests (%0d with restart) over %0d target tables, %0d results checked",
             requests_sent, restarts_sent, tables_loaded, results_checked);
    $display("counts 0, 1, 8 and saturated, empty and full masks, with and without idling");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/cbfm_pkg.sv
hdl/cbfm_cell.sv
hdl/capability_best_fit_matcher.sv
tb/sv/tb_capability_best_fit_matcher.sv
